// ----- src/rls_pkg.sv -----
// Package for the RLS adaptive FIR core: widths, register indexes, states, arithmetic helpers.
package rls_pkg;

    localparam int NUM_TAPS_DEF   = 8;
    localparam int DATA_W         = 16;
    localparam int COEF_W         = 32;
    localparam int ACC_W          = 64;
    localparam int DIV_NUM_W      = 57;
    localparam int DIV_DEN_W      = 48;
    localparam int MU_W           = 17;
    localparam int DIAG_W         = 31;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_FORGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK   = 2'd2;

    localparam logic [MU_W-1:0]   MU_RST   = 17'd65209;
    localparam logic [DIAG_W-1:0] DIAG_RST = 31'd16777216;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_Y,
        ST_OUT,
        ST_PU,
        ST_UP,
        ST_DEN,
        ST_G,
        ST_PUPD,
        ST_W
    } t_state;

    function automatic logic signed [ACC_W-1:0] f_rnd(input logic signed [ACC_W-1:0] v,
                                                       input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [COEF_W-1:0] f_sat32(input logic signed [ACC_W-1:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[COEF_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] f_sat16(input logic signed [ACC_W-1:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

// ----- src/rls_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/rls_div.sv -----
// Bit-serial signed divider, quotient truncated toward zero and saturated to 32 bits.
module rls_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [rls_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic signed [rls_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                                  o_done,
    output logic signed [rls_pkg::COEF_W-1:0]     o_quo
);

    localparam int NW  = rls_pkg::DIV_NUM_W;
    localparam int DW  = rls_pkg::DIV_DEN_W;
    localparam int MW  = NW - 1;
    localparam int CW  = $clog2(MW + 1);

    logic [MW-1:0]        r_q;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_dmag;
    logic                 r_neg;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [NW-1:0]        num_abs;
    logic [DW-1:0]        den_abs;
    logic [DW:0]          rem_sh;
    logic                 ge;
    logic [DW:0]          rem_nx;
    logic                 over;

    assign num_abs = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign den_abs = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    assign rem_sh  = {r_rem, r_q[MW-1]};
    assign ge      = rem_sh >= {1'b0, r_dmag};
    assign rem_nx  = ge ? rem_sh - {1'b0, r_dmag} : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= num_abs[MW-1:0];
            r_rem  <= '0;
            r_dmag <= den_abs;
            r_neg  <= i_num[NW-1] ^ i_den[DW-1];
        end else if (r_busy) begin
            r_q   <= {r_q[MW-2:0], ge};
            r_rem <= rem_nx[DW-1:0];
        end
    end

    assign over   = |r_q[MW-1:rls_pkg::COEF_W];
    assign o_done = r_done;

    always_comb begin
        if (r_neg) begin
            if (over || (r_q[rls_pkg::COEF_W-1] && |r_q[rls_pkg::COEF_W-2:0])) begin
                o_quo = 32'sh80000000;
            end else begin
                o_quo = -$signed(r_q[rls_pkg::COEF_W-1:0]);
            end
        end else begin
            if (over || r_q[rls_pkg::COEF_W-1]) begin
                o_quo = 32'sh7fffffff;
            end else begin
                o_quo = $signed(r_q[rls_pkg::COEF_W-1:0]);
            end
        end
    end

endmodule

// ----- src/rls_adaptive_fir_core.sv -----
// Top level of the RLS adaptive FIR core: sequencer, shared multiplier, divider, P memory.
//
// Input channel (i_in_valid / o_in_ready) moves one sample and one desired sample
// per transfer; the output channel (o_out_valid / i_out_ready) moves the filter
// output and the error. Configuration writes use i_cfg_valid / o_cfg_ready with
// a register index and data; o_cfg_ready is always high.
// One item is worked at a time: the filter output and error are computed first and
// loaded into the output register; unless the lock flag is set, the gain and P update
// follow before the next input transfer. The P update is the longest part: each of
// the N*N entries goes through one 56-step bit-serial divide by mu.
// With the lock flag set, an item takes only the output part.
// The result sits in an output register; a stalled receiver holds it there and
// the core keeps updating, then waits before loading the next result.
// After reset, and after each diagonal-load write, the core sweeps the P memory,
// writing each of the N*N entries to load the diagonal value times I; o_in_ready is
// low during the sweep. Weights and the delay line clear at once.
module rls_adaptive_fir_core #(
    parameter int NUM_TAPS = rls_pkg::NUM_TAPS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [rls_pkg::DATA_W-1:0]       i_sample_in,
    input  logic signed [rls_pkg::DATA_W-1:0]       i_desired_in,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [rls_pkg::DATA_W-1:0]       o_filter_out,
    output logic signed [rls_pkg::DATA_W-1:0]       o_error_out,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [rls_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    localparam int N  = NUM_TAPS;
    localparam int IW = $clog2(N);
    localparam int AW = $clog2(N * N);
    localparam int DW = rls_pkg::DATA_W;
    localparam int CW = rls_pkg::COEF_W;
    localparam int XW = rls_pkg::ACC_W;
    localparam logic [IW-1:0] LAST = IW'(N - 1);

    rls_pkg::t_state r_state, n_state;

    logic [IW-1:0]          r_i, n_i, r_k, n_k;
    logic [1:0]             r_sub, n_sub;
    logic signed [DW-1:0]   r_u  [N];
    logic signed [DW-1:0]   n_u  [N];
    logic signed [CW-1:0]   r_w  [N];
    logic signed [CW-1:0]   n_w  [N];
    logic signed [CW-1:0]   r_pu [N];
    logic signed [CW-1:0]   n_pu [N];
    logic signed [CW-1:0]   r_up [N];
    logic signed [CW-1:0]   n_up [N];
    logic signed [CW-1:0]   r_g  [N];
    logic signed [CW-1:0]   n_g  [N];
    logic signed [XW-1:0]   r_acc, n_acc, r_prod;
    logic signed [CW-1:0]   r_pold, n_pold;
    logic signed [DW-1:0]   r_d, n_d, r_y, n_y, r_e, n_e;
    logic signed [rls_pkg::DIV_DEN_W-1:0] r_den, n_den;
    logic [rls_pkg::MU_W-1:0]   r_mu, n_mu;
    logic [rls_pkg::DIAG_W-1:0] r_diag, n_diag;
    logic                   r_lock, n_lock;
    logic                   r_out_valid, n_out_valid;
    logic signed [DW-1:0]   r_fout, n_fout, r_eout, n_eout;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr, addr_ik, addr_ki;
    logic [CW-1:0]          ram_wdata, ram_rdata;

    logic signed [CW-1:0]   op_a, op_b, u_ext;
    logic                   div_start, div_done;
    logic signed [rls_pkg::DIV_NUM_W-1:0] div_num;
    logic signed [rls_pkg::DIV_DEN_W-1:0] div_den;
    logic signed [CW-1:0]   div_quo;

    logic [rls_pkg::MU_W-1:0] mu_eff;
    logic                   last_k, last_i;
    logic signed [DW-1:0]   y_val;
    logic signed [XW-1:0]   diff;

    rls_ram #(
        .WIDTH (CW),
        .DEPTH (N * N)
    ) u_pmem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign addr_ik   = AW'(int'(r_i) * N + int'(r_k));
    assign addr_ki   = AW'(int'(r_k) * N + int'(r_i));
    assign ram_raddr = (r_state == rls_pkg::ST_UP) ? addr_ki : addr_ik;
    assign ram_waddr = addr_ik;
    assign u_ext     = CW'(r_u[r_k]);
    assign mu_eff    = (r_mu == '0) ? rls_pkg::MU_W'(1) : r_mu;
    assign last_k    = r_k == LAST;
    assign last_i    = r_i == LAST;
    assign y_val     = rls_pkg::f_sat16(rls_pkg::f_rnd(r_acc, 24));
    assign diff      = XW'(r_pold) - rls_pkg::f_rnd(r_prod, 24);

    always_comb begin
        case (r_state)
            rls_pkg::ST_Y: begin
                op_a = r_w[r_k];
                op_b = u_ext;
            end
            rls_pkg::ST_PU, rls_pkg::ST_UP: begin
                op_a = $signed(ram_rdata);
                op_b = u_ext;
            end
            rls_pkg::ST_DEN: begin
                op_a = r_up[r_k];
                op_b = u_ext;
            end
            rls_pkg::ST_PUPD: begin
                op_a = r_g[r_i];
                op_b = r_up[r_k];
            end
            rls_pkg::ST_W: begin
                op_a = CW'(r_e);
                op_b = r_g[r_k];
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_k         = r_k;
        n_sub       = r_sub;
        n_u         = r_u;
        n_w         = r_w;
        n_pu        = r_pu;
        n_up        = r_up;
        n_g         = r_g;
        n_acc       = r_acc;
        n_pold      = r_pold;
        n_d         = r_d;
        n_y         = r_y;
        n_e         = r_e;
        n_den       = r_den;
        n_mu        = r_mu;
        n_diag      = r_diag;
        n_lock      = r_lock;
        n_out_valid = r_out_valid;
        n_fout      = r_fout;
        n_eout      = r_eout;
        ram_we      = 1'b0;
        ram_wdata   = '0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rls_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = (r_i == r_k) ? CW'(r_diag) : '0;
                if (last_k) begin
                    n_k = '0;
                    n_i = r_i + IW'(1);
                    if (last_i) begin
                        n_i     = '0;
                        n_state = rls_pkg::ST_IDLE;
                    end
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            rls_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    for (int t = 0; t < N - 1; t++) begin
                        n_u[t] = r_u[t + 1];
                    end
                    n_u[N-1] = i_sample_in;
                    n_d      = i_desired_in;
                    n_i      = '0;
                    n_k      = '0;
                    n_sub    = '0;
                    n_acc    = '0;
                    n_state  = rls_pkg::ST_Y;
                end
            end
            rls_pkg::ST_Y, rls_pkg::ST_PU, rls_pkg::ST_UP, rls_pkg::ST_DEN: begin
                case (r_sub)
                    2'd0: n_sub = 2'd1;
                    2'd1: n_sub = 2'd2;
                    2'd2: begin
                        n_acc = r_acc + r_prod;
                        if (last_k) begin
                            n_sub = 2'd3;
                        end else begin
                            n_k   = r_k + IW'(1);
                            n_sub = 2'd0;
                        end
                    end
                    default: begin
                        n_acc = '0;
                        n_k   = '0;
                        n_sub = 2'd0;
                        case (r_state)
                            rls_pkg::ST_Y: begin
                                n_y     = y_val;
                                n_e     = rls_pkg::f_sat16(XW'(r_d) - XW'(y_val));
                                n_state = rls_pkg::ST_OUT;
                            end
                            rls_pkg::ST_PU: begin
                                n_pu[r_i] = rls_pkg::f_sat32(rls_pkg::f_rnd(r_acc, 15));
                                n_i       = r_i + IW'(1);
                                if (last_i) begin
                                    n_i     = '0;
                                    n_state = rls_pkg::ST_UP;
                                end
                            end
                            rls_pkg::ST_UP: begin
                                n_up[r_i] = rls_pkg::f_sat32(rls_pkg::f_rnd(r_acc, 15));
                                n_i       = r_i + IW'(1);
                                if (last_i) begin
                                    n_i     = '0;
                                    n_state = rls_pkg::ST_DEN;
                                end
                            end
                            default: begin
                                n_den   = $signed({23'b0, mu_eff, 8'b0})
                                        + rls_pkg::DIV_DEN_W'(rls_pkg::f_rnd(r_acc, 15));
                                n_i     = '0;
                                n_state = rls_pkg::ST_G;
                            end
                        endcase
                    end
                endcase
            end
            rls_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_fout      = r_y;
                    n_eout      = r_e;
                    n_i         = '0;
                    n_k         = '0;
                    n_sub       = '0;
                    n_acc       = '0;
                    n_state     = r_lock ? rls_pkg::ST_IDLE : rls_pkg::ST_PU;
                end
            end
            rls_pkg::ST_G: begin
                if (r_sub == 2'd0) begin
                    if (r_den == '0) begin
                        if (r_pu[r_i] > 0) begin
                            n_g[r_i] = 32'sh7fffffff;
                        end else if (r_pu[r_i] < 0) begin
                            n_g[r_i] = 32'sh80000000;
                        end else begin
                            n_g[r_i] = '0;
                        end
                        n_i = r_i + IW'(1);
                        if (last_i) begin
                            n_i     = '0;
                            n_k     = '0;
                            n_state = rls_pkg::ST_PUPD;
                        end
                    end else begin
                        div_start = 1'b1;
                        div_num   = {r_pu[r_i][CW-1], r_pu[r_i], 24'b0};
                        div_den   = r_den;
                        n_sub     = 2'd1;
                    end
                end else if (div_done) begin
                    n_g[r_i] = div_quo;
                    n_sub    = 2'd0;
                    n_i      = r_i + IW'(1);
                    if (last_i) begin
                        n_i     = '0;
                        n_k     = '0;
                        n_state = rls_pkg::ST_PUPD;
                    end
                end
            end
            rls_pkg::ST_PUPD: begin
                case (r_sub)
                    2'd0: n_sub = 2'd1;
                    2'd1: begin
                        n_pold = $signed(ram_rdata);
                        n_sub  = 2'd2;
                    end
                    2'd2: begin
                        div_start = 1'b1;
                        div_num   = {diff[40:0], 16'b0};
                        div_den   = rls_pkg::DIV_DEN_W'(mu_eff);
                        n_sub     = 2'd3;
                    end
                    default: begin
                        if (div_done) begin
                            ram_we    = 1'b1;
                            ram_wdata = div_quo;
                            n_sub     = 2'd0;
                            if (last_k) begin
                                n_k = '0;
                                n_i = r_i + IW'(1);
                                if (last_i) begin
                                    n_i     = '0;
                                    n_state = rls_pkg::ST_W;
                                end
                            end else begin
                                n_k = r_k + IW'(1);
                            end
                        end
                    end
                endcase
            end
            rls_pkg::ST_W: begin
                if (r_sub == 2'd0) begin
                    n_sub = 2'd1;
                end else begin
                    n_w[r_k] = rls_pkg::f_sat32(XW'(r_w[r_k]) + rls_pkg::f_rnd(r_prod, 15));
                    n_sub    = 2'd0;
                    n_k      = r_k + IW'(1);
                    if (last_k) begin
                        n_k     = '0;
                        n_state = rls_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = rls_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            case (i_cfg_index)
                rls_pkg::CFG_FORGET: n_mu = i_cfg_data[rls_pkg::MU_W-1:0];
                rls_pkg::CFG_DIAG: begin
                    n_diag  = i_cfg_data[rls_pkg::DIAG_W-1:0];
                    n_state = rls_pkg::ST_CLEAR;
                    n_i     = '0;
                    n_k     = '0;
                    n_sub   = '0;
                    for (int t = 0; t < N; t++) begin
                        n_u[t] = '0;
                        n_w[t] = '0;
                    end
                end
                rls_pkg::CFG_LOCK: n_lock = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rls_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= '0;
            r_k         <= '0;
            r_sub       <= '0;
            r_mu        <= rls_pkg::MU_RST;
            r_diag      <= rls_pkg::DIAG_RST;
            r_lock      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < N; t++) begin
                r_u[t] <= '0;
                r_w[t] <= '0;
            end
        end else begin
            r_i         <= n_i;
            r_k         <= n_k;
            r_sub       <= n_sub;
            r_mu        <= n_mu;
            r_diag      <= n_diag;
            r_lock      <= n_lock;
            r_out_valid <= n_out_valid;
            r_u         <= n_u;
            r_w         <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pu   <= n_pu;
        r_up   <= n_up;
        r_g    <= n_g;
        r_acc  <= n_acc;
        r_prod <= op_a * op_b;
        r_pold <= n_pold;
        r_d    <= n_d;
        r_y    <= n_y;
        r_e    <= n_e;
        r_den  <= n_den;
        r_fout <= n_fout;
        r_eout <= n_eout;
    end

    assign o_out_valid  = r_out_valid;
    assign o_filter_out = r_fout;
    assign o_error_out  = r_eout;
    assign o_cfg_ready  = 1'b1;

endmodule

// ----- tb/tb_rls_adaptive_fir_core.sv -----
// Testbench for rls_adaptive_fir_core: directed and random samples, checked against an RLS predictor.
`timescale 1ns / 1ps

module tb_rls_adaptive_fir_core;

    localparam int NTAP        = rls_pkg::NUM_TAPS_DEF;
    localparam int DW          = rls_pkg::DATA_W;
    localparam int IXW         = rls_pkg::CFG_IDX_W;
    localparam int CDW         = rls_pkg::CFG_DATA_W;
    localparam int SETTLE_CYC  = 6000;
    localparam int STALL_LIMIT = 50000;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam logic [IXW-1:0] CFG_NONE = 2'd3;

    typedef struct {
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] e;
    } t_fir_result;

    class rls_scoreboard;
        longint taps [NTAP-1];
        longint wts  [NTAP];
        longint pmat [NTAP*NTAP];
        longint mu_reg;
        longint diag_reg;
        bit     lock_reg;
        t_fir_result pending[$];
        int errors;
        int n_in;
        int n_out;
        int n_locked;

        function new();
            mu_reg   = rls_pkg::MU_RST;
            diag_reg = rls_pkg::DIAG_RST;
            lock_reg = 0;
            restart();
        endfunction

        function void restart();
            foreach (taps[i]) taps[i] = 0;
            foreach (wts[i]) wts[i] = 0;
            foreach (pmat[i]) pmat[i] = (i % (NTAP + 1) == 0) ? diag_reg : 0;
        endfunction

        function longint rnd_shift(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function void write_reg(logic [IXW-1:0] idx, logic [CDW-1:0] data);
            case (idx)
                rls_pkg::CFG_FORGET: mu_reg = data[rls_pkg::MU_W-1:0];
                rls_pkg::CFG_DIAG: begin
                    diag_reg = data[rls_pkg::DIAG_W-1:0];
                    restart();
                end
                rls_pkg::CFG_LOCK: lock_reg = data[0];
                default: ;
            endcase
        endfunction

        function void note_input(logic signed [DW-1:0] x, logic signed [DW-1:0] d);
            longint u [NTAP];
            longint pu [NTAP];
            longint up [NTAP];
            longint g [NTAP];
            longint acc, a, b, den, mu, y, e, diff;
            t_fir_result r;
            n_in++;
            for (int i = 0; i < NTAP - 1; i++) u[i] = taps[i];
            u[NTAP-1] = x;
            for (int i = 0; i < NTAP - 1; i++) taps[i] = u[i+1];
            acc = 0;
            for (int k = 0; k < NTAP; k++) acc += wts[k] * u[k];
            y = clamp(rnd_shift(acc, 24), -32768, 32767);
            e = clamp(longint'(d) - y, -32768, 32767);
            r.y = y[DW-1:0];
            r.e = e[DW-1:0];
            pending.push_back(r);
            if (lock_reg) begin
                n_locked++;
                return;
            end
            mu = (mu_reg == 0) ? 1 : mu_reg;
            for (int i = 0; i < NTAP; i++) begin
                a = 0;
                b = 0;
                for (int k = 0; k < NTAP; k++) begin
                    a += pmat[i*NTAP+k] * u[k];
                    b += u[k] * pmat[k*NTAP+i];
                end
                pu[i] = clamp(rnd_shift(a, 15), S32_MIN, S32_MAX);
                up[i] = clamp(rnd_shift(b, 15), S32_MIN, S32_MAX);
            end
            acc = 0;
            for (int k = 0; k < NTAP; k++) acc += up[k] * u[k];
            den = mu * 256 + rnd_shift(acc, 15);
            for (int i = 0; i < NTAP; i++) begin
                if (den == 0)
                    g[i] = pu[i] > 0 ? S32_MAX : (pu[i] < 0 ? S32_MIN : 0);
                else
                    g[i] = clamp((pu[i] * 16777216) / den, S32_MIN, S32_MAX);
            end
            for (int i = 0; i < NTAP; i++) begin
                for (int k = 0; k < NTAP; k++) begin
                    diff = pmat[i*NTAP+k] - rnd_shift(g[i] * up[k], 24);
                    pmat[i*NTAP+k] = clamp((diff * 65536) / mu, S32_MIN, S32_MAX);
                end
            end
            for (int i = 0; i < NTAP; i++)
                wts[i] = clamp(wts[i] + rnd_shift(e * g[i], 15), S32_MIN, S32_MAX);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check(logic signed [DW-1:0] y, logic signed [DW-1:0] e);
            t_fir_result r;
            n_out++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result y=%0d e=%0d", y, e));
                return;
            end
            r = pending.pop_front();
            if (y !== r.y) report($sformatf("filter_out %0d, expected %0d", y, r.y));
            if (e !== r.e) report($sformatf("error_out %0d, expected %0d", e, r.e));
        endtask
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_in_valid = 0;
    logic                 o_in_ready;
    logic signed [DW-1:0] i_sample_in = 0;
    logic signed [DW-1:0] i_desired_in = 0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1;
    logic signed [DW-1:0] o_filter_out;
    logic signed [DW-1:0] o_error_out;
    logic                 i_cfg_valid = 0;
    logic                 o_cfg_ready;
    logic [IXW-1:0]       i_cfg_index = 0;
    logic [CDW-1:0]       i_cfg_data = 0;

    rls_scoreboard sb = new();
    bit burst = 0;
    int stall_cnt = 0;
    int quiet_cnt = 0;
    int cfg_writes = 0;

    rls_adaptive_fir_core u_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) sb.note_input(i_sample_in, i_desired_in);
        if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
    end

    // receiver stall drawn per result
    always @(posedge i_clk) begin
        int stall;
        if (o_out_valid && i_out_ready) begin
            sb.check(o_filter_out, o_error_out);
            stall = burst ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_out_ready <= 0;
                stall_cnt <= stall;
            end
        end else if (!i_out_ready) begin
            if (stall_cnt <= 1) i_out_ready <= 1;
            stall_cnt <= stall_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task send_sample(logic signed [DW-1:0] x, logic signed [DW-1:0] d);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1;
        i_sample_in  <= x;
        i_desired_in <= d;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task write_reg(logic [IXW-1:0] idx, logic [CDW-1:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    function automatic logic signed [DW-1:0] pick_sample(int mode);
        case (mode)
            0: return DW'($urandom_range(0, 65535));
            1: return DW'($signed(17'($urandom_range(0, 8191))) - 17'sd4096);
            default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    task run_random(int n, int mode);
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
            send_sample(pick_sample(mode), pick_sample($urandom_range(0, 3) == 0 ? 0 : mode));
        end
        burst = 0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: field extremes under reset settings
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sd0, 16'sd0);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd1, 16'sd0);
        for (int i = 0; i < 13; i++)
            send_sample(i[0] ? 16'sh4000 : -16'sh4000, i[1] ? 16'sh7fff : 16'sh8000);

        drain();
        write_reg(rls_pkg::CFG_FORGET, 31'd65536);
        write_reg(rls_pkg::CFG_DIAG, 31'd16777216);
        run_random(300, 1);

        drain();
        write_reg(rls_pkg::CFG_FORGET, 31'd60000);
        write_reg(rls_pkg::CFG_DIAG, 31'd1048576);
        run_random(300, 0);

        drain();
        write_reg(rls_pkg::CFG_LOCK, 31'd1);
        run_random(150, 0);
        run_random(50, 2);
        drain();
        write_reg(rls_pkg::CFG_LOCK, 31'd0);

        // zero forget factor acts as the smallest step
        drain();
        write_reg(rls_pkg::CFG_FORGET, 31'd0);
        run_random(60, 1);

        drain();
        write_reg(rls_pkg::CFG_FORGET, 31'h1ffff);
        write_reg(rls_pkg::CFG_DIAG, 31'h7fffffff);
        run_random(100, 0);

        drain();
        write_reg(rls_pkg::CFG_DIAG, 31'd0);
        run_random(100, 0);

        // out-of-range index must be ignored
        drain();
        write_reg(CFG_NONE, 31'h7fffffff);
        write_reg(rls_pkg::CFG_FORGET, 31'd65209);
        write_reg(rls_pkg::CFG_DIAG, 31'd16777216);
        run_random(470, int'($urandom_range(0, 1)));

        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.pending.size() != 0) sb.report("results left outstanding");
        $display("covered %0d samples (%0d with adaptation frozen), %0d results, %0d reg writes",
                 sb.n_in, sb.n_locked, sb.n_out, cfg_writes);
        $display("forget factors 0..131071, diagonal loads 0..max, mismatches %0d", sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
src/rls_pkg.sv
src/rls_ram.sv
src/rls_div.sv
src/rls_adaptive_fir_core.sv
tb/tb_rls_adaptive_fir_core.sv
